### sv/ohash_pkg.sv
// Shared types and constants of the open-addressing hash table.
// Used by ohash_ctrl, ohash_dp and open_addressing_hash_table.
package ohash_pkg;

    // Table geometry; SLOTS is a power of two so hash mod SLOTS is a mask
    localparam int SLOTS      = 256;
    localparam int SLOT_W     = $clog2(SLOTS);
    localparam int VALUE_BITS = 64;
    localparam int KEY_W      = 32;
    localparam int HASH_W     = 32;
    localparam int LIM_W      = 8;
    localparam int CNT_W      = $clog2(SLOTS + 1);
    localparam int CMP_W      = ((CNT_W > LIM_W) ? CNT_W : LIM_W) + 1;
    localparam int LIM_RESET  = 128;

    // Operation codes
    typedef enum logic [1:0] {
        KIND_GET = 2'd0,
        KIND_SET = 2'd1,
        KIND_DEL = 2'd2
    } t_kind;

    // Controller to datapath
    typedef struct packed {
        logic load;     // latch item, point read address at home slot
        logic advance;  // move read address to next slot
        logic check;    // read data valid, not stopping: note tombstones
        logic finish;   // probe ended on read data: commit and report
        logic quick;    // item resolved without probing: report only
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic quick;    // incoming item needs no probe
        logic stop;     // slot in read data holds the key or is empty
    } t_sts;

endpackage

### sv/ohash_ctrl.sv
// Probe sequencer of the hash table: accepts items and steps the datapath.
// Depends on ohash_pkg.
module ohash_ctrl import ohash_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    input  t_sts i_sts,
    output t_cmd o_cmd,
    output logic busy
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FIRST,
        ST_CHECK
    } t_state;

    t_state r_state, n_state;

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    if (i_sts.quick) begin
                        o_cmd.quick = 1'b1;
                    end else begin
                        o_cmd.load = 1'b1;
                        n_state    = ST_FIRST;
                    end
                end
            end
            ST_FIRST: begin
                // home slot read in flight
                o_cmd.advance = 1'b1;
                n_state       = ST_CHECK;
            end
            ST_CHECK: begin
                if (i_sts.stop) begin
                    o_cmd.finish = 1'b1;
                    n_state      = ST_IDLE;
                end else begin
                    o_cmd.advance = 1'b1;
                    o_cmd.check   = 1'b1;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy = (r_state != ST_IDLE);

endmodule

### sv/ohash_dp.sv
// Datapath of the hash table: slot memories, slot flags, fill count,
// load limit register and result register. Depends on ohash_pkg.
module ohash_dp import ohash_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    output t_sts                  o_sts,
    input  logic                  i_cfg_we,
    input  logic [LIM_W-1:0]      i_cfg_data,
    input  logic [1:0]            i_kind,
    input  logic [KEY_W-1:0]      i_key_id,
    input  logic [HASH_W-1:0]     i_key_hash,
    input  logic [63:0]           i_write_value,
    output logic                  o_valid,
    output logic                  o_hit,
    output logic [63:0]           o_read_value,
    output logic                  o_status
);

    // Slot storage
    logic [KEY_W-1:0]      mem_key  [SLOTS];
    logic [VALUE_BITS-1:0] mem_data [SLOTS];
    logic [SLOTS-1:0]      r_used, r_tomb;

    // Item and probe registers
    logic [1:0]            r_kind;
    logic [KEY_W-1:0]      r_key;
    logic [VALUE_BITS-1:0] r_wval;
    logic [SLOT_W-1:0]     r_addr;
    logic [SLOT_W-1:0]     r_rd_idx;
    logic [KEY_W-1:0]      r_rd_key;
    logic [VALUE_BITS-1:0] r_rd_data;
    logic                  r_rd_used, r_rd_tomb;
    logic                  r_have_tomb;
    logic [SLOT_W-1:0]     r_tomb_idx;

    logic [CNT_W-1:0]      r_filled;
    logic [LIM_W-1:0]      r_limit;

    logic                  r_valid, r_hit, r_status;
    logic [VALUE_BITS-1:0] r_val;

    logic                  match, empty, reject, is_set, is_get, is_del, i_set;
    logic [CMP_W-1:0]      eff_limit, need;
    logic [SLOT_W-1:0]     target;
    logic                  do_write, do_delete, grow;

    // Load check, with the limit held below the slot count
    always_comb begin
        eff_limit = (CMP_W'(r_limit) > CMP_W'(SLOTS - 1)) ? CMP_W'(SLOTS - 1)
                                                           : CMP_W'(r_limit);
        need      = CMP_W'(r_filled) + CMP_W'(1);
        reject    = (need > eff_limit);
        i_set     = (i_kind == KIND_SET);
    end

    // Items that finish without a probe
    always_comb begin
        case (i_kind)
            KIND_GET, KIND_DEL: o_sts.quick = (r_filled == '0);
            KIND_SET:           o_sts.quick = reject;
            default:            o_sts.quick = 1'b1;
        endcase
    end

    // Probe outcome on the read data
    assign match      = r_rd_used && (r_rd_key == r_key);
    assign empty      = !r_rd_used && !r_rd_tomb;
    assign o_sts.stop = match || empty;

    assign is_get    = (r_kind == KIND_GET);
    assign is_set    = (r_kind == KIND_SET);
    assign is_del    = (r_kind == KIND_DEL);
    assign target    = (!match && r_have_tomb) ? r_tomb_idx : r_rd_idx;
    assign do_write  = i_cmd.finish && is_set;
    assign do_delete = i_cmd.finish && is_del && match;
    assign grow      = do_write && !match && !r_have_tomb;

    // Key and value memories: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (do_write) begin
            mem_key[target]  <= r_key;
            mem_data[target] <= r_wval;
        end
        r_rd_key  <= mem_key[r_addr];
        r_rd_data <= mem_data[r_addr];
        r_rd_idx  <= r_addr;
        r_rd_used <= r_used[r_addr];
        r_rd_tomb <= r_tomb[r_addr];
    end

    // Slot flags, fill count and load limit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used   <= '0;
            r_tomb   <= '0;
            r_filled <= '0;
            r_limit  <= LIM_W'(LIM_RESET);
        end else begin
            if (do_write) begin
                r_used[target] <= 1'b1;
                r_tomb[target] <= 1'b0;
            end
            if (do_delete) begin
                r_used[r_rd_idx] <= 1'b0;
                r_tomb[r_rd_idx] <= 1'b1;
            end
            if (grow) begin
                r_filled <= r_filled + CNT_W'(1);
            end
            if (i_cfg_we) begin
                r_limit <= i_cfg_data;
            end
        end
    end

    // Item latch, probe address and first tombstone
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind      <= i_kind;
            r_key       <= i_key_id;
            r_wval      <= i_write_value[VALUE_BITS-1:0];
            r_addr      <= i_key_hash[SLOT_W-1:0];
            r_have_tomb <= 1'b0;
        end else begin
            if (i_cmd.advance) begin
                r_addr <= r_addr + SLOT_W'(1);
            end
            if (i_cmd.check && r_rd_tomb && !r_rd_used && !r_have_tomb) begin
                r_have_tomb <= 1'b1;
                r_tomb_idx  <= r_rd_idx;
            end
        end
    end

    // Result register, shown for one cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.finish || i_cmd.quick;
        end
        if (i_cmd.quick) begin
            r_hit    <= 1'b0;
            r_val    <= '0;
            r_status <= i_set && reject;
        end else if (i_cmd.finish) begin
            r_hit    <= is_set ? !match : ((is_get || is_del) && match);
            r_val    <= (is_get && match) ? r_rd_data : '0;
            r_status <= 1'b0;
        end
    end

    assign o_valid      = r_valid;
    assign o_hit        = r_hit;
    assign o_read_value = 64'(r_val);
    assign o_status     = r_status;

endmodule

### sv/open_addressing_hash_table.sv
// Top level of the open-addressing hash table with linear probing.
// Depends on ohash_pkg, ohash_ctrl and ohash_dp.
//
// Usage:
//   An item (i_kind, i_key_id, i_key_hash, i_write_value) is taken at a
//   clock edge with start high and busy low. kind 0 gets, 1 sets, 2 deletes.
//   Each item gives one result on o_hit, o_read_value, o_status, marked by
//   o_valid for one cycle; the receiver cannot stall it, so capture it then.
//   Items that need no probe (get or delete while the fill count is zero, a set
//   refused by the load limit, an unknown kind) give their result the next
//   cycle and keep busy low, so they may follow one per cycle.
//   A probing item first waits for the registered read of the home slot,
//   then visits one slot per cycle from the single read port of the key
//   and value memories. busy drops in the cycle the result shows, so the
//   next item may be taken then.
//   i_cfg_we writes i_cfg_data into the load limit; write only when idle.
//   Reset (i_rst_n low, synchronous) clears all slot flags, zeroes the fill
//   count and sets the load limit to 128.
module open_addressing_hash_table import ohash_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [1:0]        i_kind,
    input  logic [KEY_W-1:0]  i_key_id,
    input  logic [HASH_W-1:0] i_key_hash,
    input  logic [63:0]       i_write_value,
    input  logic              i_cfg_we,
    input  logic [LIM_W-1:0]  i_cfg_data,
    output logic              o_valid,
    output logic              o_hit,
    output logic [63:0]       o_read_value,
    output logic              o_status
);

    t_cmd cmd;
    t_sts sts;

    // Probe sequencer
    ohash_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .busy    (busy)
    );

    // Slot storage and result
    ohash_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_kind        (i_kind),
        .i_key_id      (i_key_id),
        .i_key_hash    (i_key_hash),
        .i_write_value (i_write_value),
        .o_valid       (o_valid),
        .o_hit         (o_hit),
        .o_read_value  (o_read_value),
        .o_status      (o_status)
    );

endmodule
